FILE: design/assert_macros.svh
// Assertion macros shared by the people counter RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define BPC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// When the antecedent holds, the consequent must hold in the next cycle.
`define BPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define BPC_ASSERT(label, clk, rst_n, prop)
`define BPC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: design/bpc_pkg.sv
// Package for the bidirectional people counter: widths, reset values,
// register indexes, sequence phases, event codes and beat types. No dependencies.
`default_nettype none

package bpc_pkg;

    localparam int TIMER_WIDTH = 16;
    localparam int CFG_TIMER_W = 16;
    localparam int COUNT_W     = 14;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int EVENT_W     = 3;
    localparam int CMP_W       = (TIMER_WIDTH > CFG_TIMER_W) ? TIMER_WIDTH : CFG_TIMER_W;

    localparam logic [CFG_TIMER_W-1:0] MATCH_WINDOW_RST  = CFG_TIMER_W'(500);
    localparam logic [CFG_TIMER_W-1:0] LOCKOUT_TICKS_RST = CFG_TIMER_W'(200);
    localparam logic [COUNT_W-1:0]     ALERT_LEVEL_RST   = COUNT_W'(10);
    localparam logic [COUNT_W-1:0]     COUNT_LIMIT_RST   = COUNT_W'(9999);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MATCH_WINDOW  = 2'd0,
        CFG_LOCKOUT_TICKS = 2'd1,
        CFG_ALERT_LEVEL   = 2'd2,
        CFG_COUNT_LIMIT   = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        PH_IDLE        = 2'd0,
        PH_ENTRY_FIRST = 2'd1,
        PH_EXIT_FIRST  = 2'd2
    } t_phase;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE       = 3'd0,
        EV_ENTRY      = 3'd1,
        EV_EXIT       = 3'd2,
        EV_EXIT_EMPTY = 3'd3,
        EV_ENTRY_FULL = 3'd4
    } t_event;

    typedef struct packed {
        logic [CFG_TIMER_W-1:0] match_window;
        logic [CFG_TIMER_W-1:0] lockout_ticks;
        logic [COUNT_W-1:0]     alert_level;
        logic [COUNT_W-1:0]     count_limit;
    } t_cfg;

    typedef struct packed {
        logic entry_level;
        logic exit_level;
        logic mode;
    } t_in_beat;

    typedef struct packed {
        logic [COUNT_W-1:0] occupancy;
        logic [COUNT_W-1:0] entries_total;
        logic [COUNT_W-1:0] exits_total;
        logic               alert;
        logic [EVENT_W-1:0] event_res;
    } t_out_beat;

endpackage

`default_nettype wire

FILE: design/bpc_in_if.sv
// Input channel of the people counter: valid/ready plus one sample beat.
// Depends on bpc_pkg.
`default_nettype none

interface bpc_in_if;
    import bpc_pkg::*;

    logic valid;
    logic ready;
    logic entry_level;
    logic exit_level;
    logic mode;

    modport source (output valid, output entry_level, output exit_level, output mode,
                    input ready);
    modport sink   (input valid, input entry_level, input exit_level, input mode,
                    output ready);
endinterface

`default_nettype wire

FILE: design/bpc_out_if.sv
// Result channel of the people counter: valid/ready plus one result beat.
// Depends on bpc_pkg.
`default_nettype none

interface bpc_out_if;
    import bpc_pkg::*;

    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] occupancy;
    logic [COUNT_W-1:0] entries_total;
    logic [COUNT_W-1:0] exits_total;
    logic               alert;
    logic [EVENT_W-1:0] event_res;

    modport source (output valid, output occupancy, output entries_total,
                    output exits_total, output alert, output event_res, input ready);
    modport sink   (input valid, input occupancy, input entries_total,
                    input exits_total, input alert, input event_res, output ready);
endinterface

`default_nettype wire

FILE: design/bpc_cfg_regs.sv
// Configuration register file of the people counter, written through a
// plain write port. Depends on bpc_pkg.
`default_nettype none

module bpc_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [bpc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [bpc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output bpc_pkg::t_cfg                       o_cfg
);
    import bpc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.match_window  <= MATCH_WINDOW_RST;
            r_cfg.lockout_ticks <= LOCKOUT_TICKS_RST;
            r_cfg.alert_level   <= ALERT_LEVEL_RST;
            r_cfg.count_limit   <= COUNT_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_MATCH_WINDOW: begin
                    r_cfg.match_window <= i_cfg_data[CFG_TIMER_W-1:0];
                end
                CFG_LOCKOUT_TICKS: begin
                    r_cfg.lockout_ticks <= i_cfg_data[CFG_TIMER_W-1:0];
                end
                CFG_ALERT_LEVEL: begin
                    r_cfg.alert_level <= i_cfg_data[COUNT_W-1:0];
                end
                CFG_COUNT_LIMIT: begin
                    r_cfg.count_limit <= i_cfg_data[COUNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: design/bpc_in_stage.sv
// Input register of the people counter: holds one sample beat until the
// core takes it. Depends on bpc_pkg and bpc_in_if.
`default_nettype none

module bpc_in_stage (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    bpc_in_if.sink           i_in,
    input  wire logic        i_advance,
    output logic             o_valid,
    output bpc_pkg::t_in_beat o_beat
);
    import bpc_pkg::*;

    logic     r_valid;
    t_in_beat r_beat;
    logic     accept;

    // Ready whenever the register is empty or is being drained this cycle.
    assign i_in.ready = !r_valid || i_advance;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_beat.entry_level <= i_in.entry_level;
            r_beat.exit_level  <= i_in.exit_level;
            r_beat.mode        <= i_in.mode;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

`default_nettype wire

FILE: design/bpc_core.sv
// Counter core: beam edge detection, sequence state machine, timers and
// saturating counts, all updated in one pass per beat. Depends on bpc_pkg.
`default_nettype none
`include "assert_macros.svh"

module bpc_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_fire,
    input  bpc_pkg::t_in_beat  i_beat,
    input  bpc_pkg::t_cfg      i_cfg,
    output bpc_pkg::t_out_beat o_result
);
    import bpc_pkg::*;

    localparam logic [TIMER_WIDTH-1:0] TMR_ONE = TIMER_WIDTH'(1);

    function automatic logic [TIMER_WIDTH-1:0] sat_inc(input logic [TIMER_WIDTH-1:0] t);
        sat_inc = (t == '1) ? t : t + TMR_ONE;
    endfunction

    t_phase                 r_phase, n_phase;
    logic                   r_prev_entry, r_prev_exit;
    logic [TIMER_WIDTH-1:0] r_tsr, n_tsr;
    logic [TIMER_WIDTH-1:0] r_tsf, n_tsf;
    logic [COUNT_W-1:0]     r_people, n_people;
    logic [COUNT_W-1:0]     r_in_cnt, n_in_cnt;
    logic [COUNT_W-1:0]     r_out_cnt, n_out_cnt;

    logic   entry_edge, exit_edge, locked, in_time, resolve, start;
    t_event evt;

    assign entry_edge = r_prev_entry && !i_beat.entry_level;
    assign exit_edge  = r_prev_exit && !i_beat.exit_level;
    assign locked     = CMP_W'(r_tsr) < CMP_W'(i_cfg.lockout_ticks);
    assign in_time    = CMP_W'(r_tsf) <= CMP_W'(i_cfg.match_window);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else if (i_fire) begin
            r_phase <= n_phase;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_people  = r_people;
        n_in_cnt  = r_in_cnt;
        n_out_cnt = r_out_cnt;
        evt       = EV_NONE;
        resolve   = 1'b0;
        start     = 1'b0;
        if (!locked) begin
            case (r_phase)
                PH_ENTRY_FIRST: begin
                    if (exit_edge && in_time) begin
                        resolve = 1'b1;
                        if (r_people >= i_cfg.count_limit) begin
                            evt = EV_ENTRY_FULL;
                        end else begin
                            evt      = EV_ENTRY;
                            n_people = r_people + 1'b1;
                            if (r_in_cnt < i_cfg.count_limit) begin
                                n_in_cnt = r_in_cnt + 1'b1;
                            end
                        end
                    end else if (!in_time) begin
                        resolve = 1'b1;
                    end
                end
                PH_EXIT_FIRST: begin
                    if (entry_edge && in_time) begin
                        resolve = 1'b1;
                        if (r_people == '0) begin
                            evt = EV_EXIT_EMPTY;
                        end else begin
                            evt      = EV_EXIT;
                            n_people = r_people - 1'b1;
                            if (r_out_cnt < i_cfg.count_limit) begin
                                n_out_cnt = r_out_cnt + 1'b1;
                            end
                        end
                    end else if (!in_time) begin
                        resolve = 1'b1;
                    end
                end
                PH_IDLE: begin
                    // An entry edge wins over a simultaneous exit edge.
                    if (entry_edge) begin
                        n_phase = PH_ENTRY_FIRST;
                        start   = 1'b1;
                    end else if (exit_edge) begin
                        n_phase = PH_EXIT_FIRST;
                        start   = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
        if (resolve) begin
            n_phase = PH_IDLE;
        end
        // Timers restart at zero on their event and advance at the end of the tick.
        n_tsr = resolve ? TMR_ONE : sat_inc(r_tsr);
        n_tsf = start ? TMR_ONE : sat_inc(r_tsf);
        if (i_beat.mode) begin
            n_people  = '0;
            n_in_cnt  = '0;
            n_out_cnt = '0;
        end
        o_result.occupancy     = n_people;
        o_result.entries_total = n_in_cnt;
        o_result.exits_total   = n_out_cnt;
        o_result.alert         = n_people >= i_cfg.alert_level;
        o_result.event_res     = evt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_entry <= 1'b1;
            r_prev_exit  <= 1'b1;
            r_tsr        <= '0;
            r_tsf        <= '0;
            r_people     <= '0;
            r_in_cnt     <= '0;
            r_out_cnt    <= '0;
        end else if (i_fire) begin
            r_prev_entry <= i_beat.entry_level;
            r_prev_exit  <= i_beat.exit_level;
            r_tsr        <= n_tsr;
            r_tsf        <= n_tsf;
            r_people     <= n_people;
            r_in_cnt     <= n_in_cnt;
            r_out_cnt    <= n_out_cnt;
        end
    end

    // A counted entry without a clear raises occupancy by exactly one.
    `BPC_ASSERT_NEXT(a_entry_inc, i_clk, i_rst_n, i_fire && !i_beat.mode && evt == EV_ENTRY, r_people == $past(r_people) + 1'b1)
    // Any reported event closes the sequence and restarts the lockout timer.
    `BPC_ASSERT_NEXT(a_event_resolves, i_clk, i_rst_n, i_fire && evt != EV_NONE, r_phase == PH_IDLE && r_tsr == TMR_ONE)
    // A locked tick never moves the sequence.
    `BPC_ASSERT_NEXT(a_locked_hold, i_clk, i_rst_n, i_fire && locked, $stable(r_phase))
    // Without a beat nothing in the counter state moves.
    `BPC_ASSERT_NEXT(a_idle_hold, i_clk, i_rst_n, !i_fire, $stable(r_people) && $stable(r_tsr) && $stable(r_phase))

endmodule

`default_nettype wire

FILE: design/bpc_out_stage.sv
// Result register of the people counter: holds one result beat until the
// consumer takes it. Depends on bpc_pkg and bpc_out_if.
`default_nettype none

module bpc_out_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  bpc_pkg::t_out_beat i_result,
    output logic               o_free,
    bpc_out_if.source          o_out
);
    import bpc_pkg::*;

    logic      r_valid;
    t_out_beat r_result;
    logic      load;

    assign o_free = !r_valid || o_out.ready;
    assign load   = i_valid && o_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.occupancy     = r_result.occupancy;
    assign o_out.entries_total = r_result.entries_total;
    assign o_out.exits_total   = r_result.exits_total;
    assign o_out.alert         = r_result.alert;
    assign o_out.event_res     = r_result.event_res;

endmodule

`default_nettype wire

FILE: design/bidirectional_people_counter_top.sv
// Top level of the two-beam bidirectional people counter.
// Depends on bpc_pkg, bpc_in_if, bpc_out_if and the bpc_* submodules.
`default_nettype none

// Each input beat is one sample tick carrying the two active-low beam levels
// and a clear request; each tick produces exactly one result beat with the
// occupancy, the entry and exit totals, the alert flag and the event code of
// that tick. The block takes one beat per clock cycle at full rate: a beat is
// captured in an input register, the core evaluates edges, the sequence state
// machine, the timers and the saturating counts in a single combinational pass,
// and the result then lands in an output register, held back while that register
// is full. The output register lets a new beat enter while a finished
// result still waits, so throughput only drops when the consumer holds ready
// low. Configuration registers (match window, lockout, alert level and count
// limit) are written through the plain write port and should only be changed
// while no beat is in flight. Reset is synchronous and active low; after reset
// the lockout timer starts at zero, so the first lockout_ticks ticks ignore
// beam edges.
module bidirectional_people_counter_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [bpc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [bpc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    bpc_in_if.sink                               i_in,
    bpc_out_if.source                            o_out
);
    import bpc_pkg::*;

    t_cfg      cfg;
    t_in_beat  in_beat;
    t_out_beat result;
    logic      in_valid;
    logic      out_free;
    logic      advance;

    // A beat moves from the input register through the core when the
    // result register can take its result in the same cycle.
    assign advance = in_valid && out_free;

    bpc_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bpc_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_beat    (in_beat)
    );

    bpc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_beat   (in_beat),
        .i_cfg    (cfg),
        .o_result (result)
    );

    bpc_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (in_valid),
        .i_result (result),
        .o_free   (out_free),
        .o_out    (o_out)
    );

endmodule

`default_nettype wire

FILE: bench/bidirectional_people_counter_top_test.sv
// Self-checking bench for the two-beam bidirectional people counter top level.
// Depends on bpc_pkg, bpc_in_if, bpc_out_if and bidirectional_people_counter_top.
`default_nettype none

module bidirectional_people_counter_top_test;
    import bpc_pkg::*;

    // A receiver hold-off this long fills the two-deep pipeline and stalls the input.
    localparam int HOLD_STRETCH = 64;
    // Cycles without any accepted beat before the run is declared hung. The longest
    // legitimate quiet stretch is the receiver hold-off plus a few config writes.
    localparam int STALL_LIMIT  = 2000;
    // Results pass through the input and output registers; wait a little longer at the end.
    localparam int DRAIN_CYCLES = 8;

    // One row of the directed stimulus. Where "typed" is set, "want" is the result
    // written out by hand; otherwise the result comes from the predictor.
    typedef struct packed {
        logic      entry_level;
        logic      exit_level;
        logic      mode;
        logic      typed;
        t_out_beat want;
    } t_directed_row;

    // The directed rows run with lockout 0, match window 2, alert level 1 and
    // count limit 2, so that every event code shows up within a few ticks.
    localparam int N_DIRECTED = 25;
    localparam t_directed_row DIRECTED [N_DIRECTED] = '{
        // Quiet tick straight after reset: everything is zero.
        '{1'b1, 1'b1, 1'b0, 1'b1, '{14'd0, 14'd0, 14'd0, 1'b0, EV_NONE}},
        // Exit beam first, then the entry beam: an exit with the room empty.
        '{1'b1, 1'b0, 1'b0, 1'b0, '0},
        '{1'b0, 1'b0, 1'b0, 1'b1, '{14'd0, 14'd0, 14'd0, 1'b0, EV_EXIT_EMPTY}},
        // Two regular entries bring the room up to the count limit.
        '{1'b1, 1'b1, 1'b0, 1'b0, '0},
        '{1'b0, 1'b1, 1'b0, 1'b0, '0},
        '{1'b0, 1'b0, 1'b0, 1'b0, '0},
        '{1'b1, 1'b1, 1'b0, 1'b0, '0},
        '{1'b0, 1'b1, 1'b0, 1'b0, '0},
        '{1'b0, 1'b0, 1'b0, 1'b0, '0},
        // A third entry is refused because the room is full.
        '{1'b1, 1'b1, 1'b0, 1'b0, '0},
        '{1'b0, 1'b1, 1'b0, 1'b0, '0},
        '{1'b0, 1'b0, 1'b0, 1'b1, '{14'd2, 14'd2, 14'd0, 1'b1, EV_ENTRY_FULL}},
        // A regular exit.
        '{1'b1, 1'b1, 1'b0, 1'b0, '0},
        '{1'b1, 1'b0, 1'b0, 1'b0, '0},
        '{1'b0, 1'b0, 1'b0, 1'b0, '0},
        // Exit beam alone: the sequence runs past the window and expires.
        '{1'b1, 1'b1, 1'b0, 1'b0, '0},
        '{1'b1, 1'b0, 1'b0, 1'b0, '0},
        '{1'b1, 1'b0, 1'b0, 1'b0, '0},
        '{1'b1, 1'b0, 1'b0, 1'b0, '0},
        '{1'b1, 1'b0, 1'b0, 1'b0, '0},
        // An entry sequence opens, a clear lands in the middle of it and the
        // entry still counts against the cleared totals.
        '{1'b0, 1'b0, 1'b0, 1'b0, '0},
        '{1'b0, 1'b1, 1'b1, 1'b1, '{14'd0, 14'd0, 14'd0, 1'b0, EV_NONE}},
        '{1'b0, 1'b0, 1'b0, 1'b0, '0},
        '{1'b1, 1'b1, 1'b1, 1'b1, '{14'd0, 14'd0, 14'd0, 1'b0, EV_NONE}},
        // Both beams fall together from idle: the entry beam wins.
        '{1'b0, 1'b0, 1'b0, 1'b0, '0}
    };

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;

    bpc_in_if  in_ch ();
    bpc_out_if out_ch ();

    bidirectional_people_counter_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    always #4 i_clk = ~i_clk;

    // Shadow of the counter: configuration registers and the sequence state.
    logic [CFG_TIMER_W-1:0] m_window;
    logic [CFG_TIMER_W-1:0] m_lockout;
    logic [COUNT_W-1:0]     m_alert;
    logic [COUNT_W-1:0]     m_limit;
    t_phase                 m_phase;
    logic                   m_prev_entry;
    logic                   m_prev_exit;
    logic [TIMER_WIDTH-1:0] m_since_resolve;
    logic [TIMER_WIDTH-1:0] m_since_first;
    logic [COUNT_W-1:0]     m_inside;
    logic [COUNT_W-1:0]     m_entries;
    logic [COUNT_W-1:0]     m_exits;

    // Result beats still owed by the block, oldest first.
    t_out_beat expected_counts [$];

    int  fail_count          = 0;
    int  beats_sent          = 0;
    bit  tx_gaps_on          = 1'b1;
    bit  rx_gaps_on          = 1'b1;
    bit  hold_stretch_pending = 1'b0;
    int  rx_stall            = 0;
    t_out_beat got_beat;
    t_out_beat want_beat;

    // Advances the shadow state by one sample tick and returns the result beat.
    function automatic t_out_beat predict_counts(t_in_beat b);
        logic      entry_edge;
        logic      exit_edge;
        logic      in_time;
        t_out_beat r;
        entry_edge  = m_prev_entry & ~b.entry_level;
        exit_edge   = m_prev_exit & ~b.exit_level;
        r           = '0;
        r.event_res = EV_NONE;
        // A locked tick only moves the levels and the timers; a clear still zeroes the counts.
        if (m_since_resolve >= m_lockout) begin
            in_time = (m_since_first <= m_window);
            case (m_phase)
                PH_ENTRY_FIRST: begin
                    if (exit_edge && in_time) begin
                        if (m_inside >= m_limit) begin
                            r.event_res = EV_ENTRY_FULL;
                        end else begin
                            m_inside = m_inside + 1'b1;
                            if (m_entries < m_limit) m_entries = m_entries + 1'b1;
                            r.event_res = EV_ENTRY;
                        end
                        m_phase         = PH_IDLE;
                        m_since_resolve = '0;
                    end else if (!in_time) begin
                        m_phase         = PH_IDLE;
                        m_since_resolve = '0;
                    end
                end
                PH_EXIT_FIRST: begin
                    if (entry_edge && in_time) begin
                        if (m_inside == '0) begin
                            r.event_res = EV_EXIT_EMPTY;
                        end else begin
                            m_inside = m_inside - 1'b1;
                            if (m_exits < m_limit) m_exits = m_exits + 1'b1;
                            r.event_res = EV_EXIT;
                        end
                        m_phase         = PH_IDLE;
                        m_since_resolve = '0;
                    end else if (!in_time) begin
                        m_phase         = PH_IDLE;
                        m_since_resolve = '0;
                    end
                end
                default: begin
                    if (entry_edge) begin
                        m_phase       = PH_ENTRY_FIRST;
                        m_since_first = '0;
                    end else if (exit_edge) begin
                        m_phase       = PH_EXIT_FIRST;
                        m_since_first = '0;
                    end
                end
            endcase
        end
        m_prev_entry = b.entry_level;
        m_prev_exit  = b.exit_level;
        if (m_since_resolve != '1) m_since_resolve = m_since_resolve + 1'b1;
        if (m_since_first != '1) m_since_first = m_since_first + 1'b1;
        // The clear request zeroes the counts after the tick; the event stays.
        if (b.mode) begin
            m_inside  = '0;
            m_entries = '0;
            m_exits   = '0;
        end
        r.occupancy     = m_inside;
        r.entries_total = m_entries;
        r.exits_total   = m_exits;
        r.alert         = (m_inside >= m_alert);
        return r;
    endfunction

    // Offers one input beat after a random gap and waits until it is accepted.
    // On return the clock edge of acceptance is current and valid is still high,
    // so the next beat can follow back to back without valid dropping.
    task automatic send_beat(t_in_beat b, logic typed, t_out_beat want);
        int        gap;
        t_out_beat predicted;
        gap = tx_gaps_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.entry_level <= b.entry_level;
        in_ch.exit_level  <= b.exit_level;
        in_ch.mode        <= b.mode;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        predicted = predict_counts(b);
        expected_counts.push_back(typed ? want : predicted);
        beats_sent++;
    endtask

    // Holds the two beam levels for a number of ticks; a rare tick also clears.
    task automatic emit_levels(logic e, logic x, int k);
        t_in_beat b;
        repeat (k) begin
            b.entry_level = e;
            b.exit_level  = x;
            b.mode        = ($urandom_range(0, 29) == 0);
            send_beat(b, 1'b0, '0);
        end
    endtask

    // Lets every owed result come out, then rewrites all four registers while
    // the block is idle. Writes run back to back with the enable held high.
    task automatic set_config(logic [15:0] mw, logic [15:0] lo, logic [15:0] al,
                              logic [15:0] cl);
        logic [15:0] vals [4];
        vals = '{mw, lo, al, cl};
        in_ch.valid <= 1'b0;
        while (expected_counts.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        for (int i = 0; i < 4; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= t_cfg_index'(i);
            i_cfg_data  <= vals[i];
            @(posedge i_clk);
        end
        i_cfg_we  <= 1'b0;
        m_window  = mw;
        m_lockout = lo;
        m_alert   = al[COUNT_W-1:0];
        m_limit   = cl[COUNT_W-1:0];
    endtask

    // Random traffic for one configuration. Most of it is people walking through
    // the two beams in either direction, with a random pause about as long as a short
    // lockout first and a beam-to-beam time around the match window. The rest is
    // beam noise and single-beam sequences that never complete.
    task automatic run_phase(int n);
        int goal;
        int kind;
        int reach;
        int pad;
        bit first_is_entry;
        goal = beats_sent + n;
        while (beats_sent < goal) begin
            reach          = ((m_window < 20) ? int'(m_window) : 20) + 2;
            pad            = (m_lockout < 16) ? int'(m_lockout) : 3;
            kind           = $urandom_range(0, 9);
            first_is_entry = 1'($urandom_range(0, 1));
            if (kind < 7) begin
                emit_levels(1'b1, 1'b1, 1 + $urandom_range(0, pad));
                if (first_is_entry) begin
                    emit_levels(1'b0, 1'b1, $urandom_range(1, reach));
                    emit_levels(1'b0, 1'b0, $urandom_range(1, 3));
                    emit_levels(1'b1, 1'b0, $urandom_range(0, 2));
                end else begin
                    emit_levels(1'b1, 1'b0, $urandom_range(1, reach));
                    emit_levels(1'b0, 1'b0, $urandom_range(1, 3));
                    emit_levels(1'b0, 1'b1, $urandom_range(0, 2));
                end
            end else if (kind < 9) begin
                repeat ($urandom_range(1, 6))
                    emit_levels(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1);
            end else begin
                if (first_is_entry) emit_levels(1'b0, 1'b1, $urandom_range(1, reach + 3));
                else emit_levels(1'b1, 1'b0, $urandom_range(1, reach + 3));
                emit_levels(1'b1, 1'b1, 1);
            end
        end
    endtask

    // Result side: every accepted result beat is compared field by field with the
    // oldest expectation. Ready drops for a random number of cycles after each
    // beat, and once for a long stretch when the stimulus asks for it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            rx_stall = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got_beat = '{out_ch.occupancy, out_ch.entries_total, out_ch.exits_total,
                             out_ch.alert, out_ch.event_res};
                if (expected_counts.size() == 0) begin
                    $error("result beat arrived with nothing expected");
                    fail_count++;
                end else begin
                    want_beat = expected_counts.pop_front();
                    if (got_beat.occupancy !== want_beat.occupancy) begin
                        $error("occupancy: expected %0d, got %0d",
                               want_beat.occupancy, got_beat.occupancy);
                        fail_count++;
                    end
                    if (got_beat.entries_total !== want_beat.entries_total) begin
                        $error("entries_total: expected %0d, got %0d",
                               want_beat.entries_total, got_beat.entries_total);
                        fail_count++;
                    end
                    if (got_beat.exits_total !== want_beat.exits_total) begin
                        $error("exits_total: expected %0d, got %0d",
                               want_beat.exits_total, got_beat.exits_total);
                        fail_count++;
                    end
                    if (got_beat.alert !== want_beat.alert) begin
                        $error("alert: expected %0d, got %0d",
                               want_beat.alert, got_beat.alert);
                        fail_count++;
                    end
                    if (got_beat.event_res !== want_beat.event_res) begin
                        $error("event_res: expected %0d, got %0d",
                               want_beat.event_res, got_beat.event_res);
                        fail_count++;
                    end
                end
                rx_stall = rx_gaps_on ? $urandom_range(0, 7) : 0;
            end
            if (hold_stretch_pending) begin
                hold_stretch_pending = 1'b0;
                rx_stall = HOLD_STRETCH;
            end
            if (rx_stall > 0) begin
                rx_stall--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: too many cycles in a row without any accepted beat means a hang.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        t_in_beat b;
        in_ch.valid       = 1'b0;
        in_ch.entry_level = 1'b1;
        in_ch.exit_level  = 1'b1;
        in_ch.mode        = 1'b0;
        out_ch.ready      = 1'b0;

        // Shadow state as the block comes out of reset.
        m_window        = MATCH_WINDOW_RST;
        m_lockout       = LOCKOUT_TICKS_RST;
        m_alert         = ALERT_LEVEL_RST;
        m_limit         = COUNT_LIMIT_RST;
        m_phase         = PH_IDLE;
        m_prev_entry    = 1'b1;
        m_prev_exit     = 1'b1;
        m_since_resolve = '0;
        m_since_first   = '0;
        m_inside        = '0;
        m_entries       = '0;
        m_exits         = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: short window, no lockout and a tiny room.
        set_config(16'd2, 16'd0, 16'd1, 16'd2);
        for (int i = 0; i < N_DIRECTED; i++) begin
            b = '{DIRECTED[i].entry_level, DIRECTED[i].exit_level, DIRECTED[i].mode};
            send_beat(b, DIRECTED[i].typed, DIRECTED[i].want);
        end

        // All registers at zero, except a limit of one: no sequence can match in
        // a zero window and the alert is always raised.
        set_config(16'd0, 16'd0, 16'd0, 16'd1);
        run_phase(150);

        // Every data bit set: the window never closes, every tick stays locked,
        // and alert level and limit are masked down to fourteen bits.
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_phase(100);

        // A small room so that the full and empty cases come up often. Midway the
        // receiver stops for a long stretch while the sender keeps pushing beats.
        set_config(16'($urandom_range(3, 12)), 16'($urandom_range(0, 3)),
                   16'($urandom_range(0, 6)), 16'($urandom_range(2, 6)));
        run_phase(150);
        tx_gaps_on = 1'b0;
        hold_stretch_pending = 1'b1;
        run_phase(100);
        tx_gaps_on = 1'b1;
        run_phase(150);

        // A short lockout with the receiver always ready.
        set_config(16'd6, 16'd4, 16'd3, 16'd9999);
        rx_gaps_on = 1'b0;
        run_phase(300);
        rx_gaps_on = 1'b1;

        // Random window and lockout; alert level and limit carry stray upper bits.
        set_config(16'($urandom_range(4, 40)), 16'($urandom_range(0, 6)),
                   {2'($urandom_range(0, 3)), 14'($urandom_range(0, 8))},
                   {2'($urandom_range(0, 3)), 14'($urandom_range(1, 10))});
        tx_gaps_on = 1'b0;
        run_phase(200);
        tx_gaps_on = 1'b1;
        run_phase(200);

        // Reset values: long lockouts leave most ticks ignored.
        set_config(MATCH_WINDOW_RST, LOCKOUT_TICKS_RST, 16'(ALERT_LEVEL_RST),
                   16'(COUNT_LIMIT_RST));
        run_phase(300);

        in_ch.valid <= 1'b0;
        while (expected_counts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
